/* design/gps_waypoint_heading_top_assert.svh */
// Assertion macros used by the waypoint heading controller
`ifndef GPS_WAYPOINT_HEADING_TOP_ASSERT_SVH
`define GPS_WAYPOINT_HEADING_TOP_ASSERT_SVH
// same-cycle implication, clocked on clk, held off during reset
`define GWH_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication, clocked on clk, held off during reset
`define GWH_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

/* design/gwh_pkg.sv */
// Shared types, constants and tables of the waypoint heading block
package gwh_pkg;

  localparam int CORDIC_STEPS_DEF = 16;
  localparam int CORDIC_MAX       = 24;

  localparam logic [1:0] NAV_LOST    = 2'd0;
  localparam logic [1:0] NAV_HEADING = 2'd1;
  localparam logic [1:0] NAV_REACHED = 2'd2;

  localparam logic [1:0] SQ_LAT = 2'd0;
  localparam logic [1:0] SQ_LON = 2'd1;
  localparam logic [1:0] SQ_RAD = 2'd2;

  localparam logic [1:0] REG_DEST_LAT = 2'd0;
  localparam logic [1:0] REG_DEST_LON = 2'd1;
  localparam logic [1:0] REG_RADIUS   = 2'd2;
  localparam logic [1:0] REG_WINDOW   = 2'd3;

  typedef struct packed {
    logic [25:0] dest_lat;
    logic [26:0] dest_lon;
    logic [15:0] radius;
    logic [3:0]  window;
  } cfg_t;

  typedef struct packed {
    logic       cap_in;
    logic       conv;
    logic       acc;
    logic       set_lost;
    logic       div_step;
    logic       set_mean;
    logic       sq_en;
    logic [1:0] sq_sel;
    logic       set_reached;
    logic       cor_init;
    logic       cor_step;
    logic [4:0] cor_idx;
    logic       cor_fin;
    logic       load_out;
  } cmd_t;

  typedef struct packed {
    logic win_end;
    logic no_fix;
    logic reached;
  } sts_t;

  function automatic logic [28:0] atan_ent(input logic [4:0] idx);
    logic [28:0] v;
    case (idx)
      5'd0:  v = 29'd294912000;
      5'd1:  v = 29'd174096719;
      5'd2:  v = 29'd91987925;
      5'd3:  v = 29'd46694507;
      5'd4:  v = 29'd23437865;
      5'd5:  v = 29'd11730358;
      5'd6:  v = 29'd5866610;
      5'd7:  v = 29'd2933484;
      5'd8:  v = 29'd1466764;
      5'd9:  v = 29'd733385;
      5'd10: v = 29'd366693;
      5'd11: v = 29'd183346;
      5'd12: v = 29'd91673;
      5'd13: v = 29'd45837;
      5'd14: v = 29'd22918;
      5'd15: v = 29'd11459;
      5'd16: v = 29'd5730;
      5'd17: v = 29'd2865;
      5'd18: v = 29'd1432;
      5'd19: v = 29'd716;
      5'd20: v = 29'd358;
      5'd21: v = 29'd179;
      5'd22: v = 29'd90;
      5'd23: v = 29'd45;
      default: v = 29'd0;
    endcase
    return v;
  endfunction

endpackage

/* design/gwh_regs.sv */
// APB configuration registers of the waypoint heading block
module gwh_regs (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  output gwh_pkg::cfg_t      cfg
);

  gwh_pkg::cfg_t cfg_r;
  logic          wr;

  assign pready = 1'b1;
  assign wr     = psel & penable & pwrite;
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.dest_lat <= '0;
      cfg_r.dest_lon <= '0;
      cfg_r.radius   <= 16'd30;
      cfg_r.window   <= 4'd10;
    end else if (wr) begin
      case (paddr[3:2])
        gwh_pkg::REG_DEST_LAT: cfg_r.dest_lat <= pwdata[25:0];
        gwh_pkg::REG_DEST_LON: cfg_r.dest_lon <= pwdata[26:0];
        gwh_pkg::REG_RADIUS:   cfg_r.radius   <= pwdata[15:0];
        gwh_pkg::REG_WINDOW:   cfg_r.window   <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      gwh_pkg::REG_DEST_LAT: prdata = {6'd0, cfg_r.dest_lat};
      gwh_pkg::REG_DEST_LON: prdata = {5'd0, cfg_r.dest_lon};
      gwh_pkg::REG_RADIUS:   prdata = {16'd0, cfg_r.radius};
      gwh_pkg::REG_WINDOW:   prdata = {28'd0, cfg_r.window};
      default:               prdata = '0;
    endcase
  end

endmodule

/* design/gwh_dp.sv */
// Datapath: BCD conversion, window sums, divider, distance check and CORDIC
module gwh_dp (
  input  logic               clk,
  input  logic               rst_n,
  input  gwh_pkg::cmd_t      cmd,
  input  gwh_pkg::cfg_t      cfg,
  input  logic               in_fix_valid,
  input  logic [31:0]        in_latitude_bcd,
  input  logic [35:0]        in_longitude_bcd,
  output gwh_pkg::sts_t      sts,
  output logic [1:0]         out_nav_status,
  output logic [15:0]        out_heading,
  output logic [25:0]        out_mean_latitude,
  output logic [26:0]        out_mean_longitude
);

  localparam logic signed [33:0] ANG_HALF = 34'sd1179648000;
  localparam logic signed [33:0] ANG_FULL = 34'sd2359296000;

  function automatic logic [20:0] bcd6(input logic [23:0] v);
    return 21'(v[3:0]) + 21'(v[7:4]) * 21'd10 + 21'(v[11:8]) * 21'd100
         + 21'(v[15:12]) * 21'd1000 + 21'(v[19:16]) * 21'd10000
         + 21'(v[23:20]) * 21'd100000;
  endfunction

  logic        fix_r;
  logic [31:0] latb_r;
  logic [35:0] lonb_r;
  logic [25:0] clat_r;
  logic [26:0] clon_r;
  logic [3:0]  tick_r, fcnt_r, dvs_r, ra_r, rb_r;
  logic [29:0] lsum_r;
  logic [30:0] osum_r, qa_r, qb_r;
  logic [25:0] mlat_r;
  logic [26:0] mlon_r;
  logic [54:0] d2_r;
  logic [31:0] r2_r;
  logic signed [47:0] x_r, y_r;
  logic signed [33:0] z_r;
  logic [1:0]  rstat_r;
  logic [15:0] rhead_r;
  logic [25:0] rlat_r;
  logic [26:0] rlon_r;

  logic [7:0]  lat_deg;
  logic [10:0] lon_deg;
  logic [28:0] lat_full;
  logic [30:0] lon_full;
  logic [3:0]  fcnt_add;
  logic [29:0] lsum_add;
  logic [30:0] osum_add;
  logic [4:0]  tick_nxt;
  logic [3:0]  win;
  logic [4:0]  ta, tb;
  logic        ga, gb;
  logic signed [26:0] dlat;
  logic signed [27:0] dlon;
  logic [25:0] alat;
  logic [26:0] alon;
  logic [26:0] sq_a;
  logic [53:0] prod;
  logic signed [47:0] xi, yi, sx, sy;
  logic signed [33:0] at, zp, zc;
  logic [34:0] hsum;
  logic [18:0] hraw;
  logic [15:0] hfin;

  assign lat_deg  = 8'(latb_r[31:28]) * 8'd10 + 8'(latb_r[27:24]);
  assign lon_deg  = 11'(lonb_r[35:32]) * 11'd100 + 11'(lonb_r[31:28]) * 11'd10
                  + 11'(lonb_r[27:24]);
  assign lat_full = 29'(lat_deg) * 29'd600000 + 29'(bcd6(latb_r[23:0]));
  assign lon_full = 31'(lon_deg) * 31'd600000 + 31'(bcd6(lonb_r[23:0]));

  assign fcnt_add = fix_r ? fcnt_r + 4'd1 : fcnt_r;
  assign lsum_add = fix_r ? lsum_r + 30'(clat_r) : lsum_r;
  assign osum_add = fix_r ? osum_r + 31'(clon_r) : osum_r;
  assign tick_nxt = {1'b0, tick_r} + 5'd1;
  assign win      = (cfg.window == 4'd0) ? 4'd1 : cfg.window;

  assign ta = {ra_r, qa_r[30]};
  assign tb = {rb_r, qb_r[30]};
  assign ga = ta >= {1'b0, dvs_r};
  assign gb = tb >= {1'b0, dvs_r};

  assign dlat = $signed({1'b0, cfg.dest_lat}) - $signed({1'b0, mlat_r});
  assign dlon = $signed({1'b0, cfg.dest_lon}) - $signed({1'b0, mlon_r});
  assign alat = dlat[26] ? 26'(-dlat) : dlat[25:0];
  assign alon = dlon[27] ? 27'(-dlon) : dlon[26:0];

  always_comb begin
    case (cmd.sq_sel)
      gwh_pkg::SQ_LAT: sq_a = {1'b0, alat};
      gwh_pkg::SQ_LON: sq_a = alon;
      gwh_pkg::SQ_RAD: sq_a = {11'd0, cfg.radius};
      default:         sq_a = '0;
    endcase
  end
  assign prod = 54'(sq_a) * 54'(sq_a);

  assign xi = 48'(dlat) <<< 16;
  assign yi = 48'(dlon) <<< 16;
  assign sx = x_r >>> cmd.cor_idx;
  assign sy = y_r >>> cmd.cor_idx;
  assign at = $signed({5'd0, gwh_pkg::atan_ent(cmd.cor_idx)});

  assign zp   = z_r[33] ? z_r + ANG_FULL : z_r;
  assign zc   = zp[33] ? '0 : zp;
  assign hsum = 35'(zc) + 35'd32768;
  assign hraw = hsum[34:16];
  assign hfin = (hraw >= 19'd36000) ? 16'(hraw - 19'd36000) : hraw[15:0];

  assign sts.win_end = tick_nxt >= {1'b0, win};
  assign sts.no_fix  = fcnt_add == 4'd0;
  assign sts.reached = d2_r <= 55'(r2_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_r <= '0;
      fcnt_r <= '0;
      lsum_r <= '0;
      osum_r <= '0;
    end else if (cmd.acc) begin
      if (sts.win_end) begin
        tick_r <= '0;
        fcnt_r <= '0;
        lsum_r <= '0;
        osum_r <= '0;
      end else begin
        tick_r <= tick_nxt[3:0];
        fcnt_r <= fcnt_add;
        lsum_r <= lsum_add;
        osum_r <= osum_add;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cap_in) begin
      fix_r  <= in_fix_valid;
      latb_r <= in_latitude_bcd;
      lonb_r <= in_longitude_bcd;
    end
    if (cmd.conv) begin
      clat_r <= (lat_full > 29'd54000000) ? 26'd54000000 : lat_full[25:0];
      clon_r <= (lon_full > 31'd108000000) ? 27'd108000000 : lon_full[26:0];
    end
    if (cmd.acc) begin
      qa_r  <= {1'b0, lsum_add};
      qb_r  <= osum_add;
      ra_r  <= '0;
      rb_r  <= '0;
      dvs_r <= fcnt_add;
    end
    if (cmd.div_step) begin
      ra_r <= ga ? 4'(ta - {1'b0, dvs_r}) : ta[3:0];
      rb_r <= gb ? 4'(tb - {1'b0, dvs_r}) : tb[3:0];
      qa_r <= {qa_r[29:0], ga};
      qb_r <= {qb_r[29:0], gb};
    end
    if (cmd.set_mean) begin
      mlat_r <= qa_r[25:0];
      mlon_r <= qb_r[26:0];
      d2_r   <= '0;
    end
    if (cmd.sq_en) begin
      if (cmd.sq_sel == gwh_pkg::SQ_RAD) r2_r <= prod[31:0];
      else d2_r <= d2_r + 55'(prod);
    end
    if (cmd.cor_init) begin
      if (xi < 0) begin
        z_r <= (yi >= 0) ? ANG_HALF : -ANG_HALF;
        x_r <= -xi;
        y_r <= -yi;
      end else begin
        z_r <= '0;
        x_r <= xi;
        y_r <= yi;
      end
    end
    if (cmd.cor_step) begin
      if (y_r >= 0) begin
        x_r <= x_r + sy;
        y_r <= y_r - sx;
        z_r <= z_r + at;
      end else begin
        x_r <= x_r - sy;
        y_r <= y_r + sx;
        z_r <= z_r - at;
      end
    end
    if (cmd.set_lost) begin
      rstat_r <= gwh_pkg::NAV_LOST;
      rhead_r <= '0;
      rlat_r  <= '0;
      rlon_r  <= '0;
    end
    if (cmd.set_reached) begin
      rstat_r <= gwh_pkg::NAV_REACHED;
      rhead_r <= '0;
      rlat_r  <= mlat_r;
      rlon_r  <= mlon_r;
    end
    if (cmd.cor_fin) begin
      rstat_r <= gwh_pkg::NAV_HEADING;
      rhead_r <= hfin;
      rlat_r  <= mlat_r;
      rlon_r  <= mlon_r;
    end
    if (cmd.load_out) begin
      out_nav_status     <= rstat_r;
      out_heading        <= rhead_r;
      out_mean_latitude  <= rlat_r;
      out_mean_longitude <= rlon_r;
    end
  end

endmodule

/* design/gwh_ctrl.sv */
// Controller state machine sequencing the waypoint heading datapath
module gwh_ctrl #(
  parameter int CORDIC_STEPS = gwh_pkg::CORDIC_STEPS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  output logic               out_valid,
  input  logic               out_stall,
  input  gwh_pkg::sts_t      sts,
  output gwh_pkg::cmd_t      cmd
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_CONV = 4'd1;
  localparam logic [3:0] S_ACC  = 4'd2;
  localparam logic [3:0] S_DIV  = 4'd3;
  localparam logic [3:0] S_MEAN = 4'd4;
  localparam logic [3:0] S_SQ   = 4'd5;
  localparam logic [3:0] S_CMP  = 4'd6;
  localparam logic [3:0] S_COR  = 4'd7;
  localparam logic [3:0] S_FIN  = 4'd8;
  localparam logic [3:0] S_DONE = 4'd9;

  localparam logic [4:0] DIV_LAST = 5'd30;
  localparam logic [4:0] COR_LAST = 5'(CORDIC_STEPS - 1);

  logic [3:0] state_r, state_nxt;
  logic [4:0] cnt_r, cnt_nxt;
  logic       out_valid_r, out_valid_nxt;

  assign in_stall  = state_r != S_IDLE;
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    cmd           = '0;
    cmd.sq_sel    = cnt_r[1:0];
    cmd.cor_idx   = cnt_r;
    out_valid_nxt = out_valid_r & out_stall;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.cap_in = 1'b1;
          state_nxt  = S_CONV;
        end
      end
      S_CONV: begin
        cmd.conv  = 1'b1;
        state_nxt = S_ACC;
      end
      S_ACC: begin
        cmd.acc = 1'b1;
        cnt_nxt = '0;
        if (!sts.win_end) begin
          state_nxt = S_IDLE;
        end else if (sts.no_fix) begin
          cmd.set_lost = 1'b1;
          state_nxt    = S_DONE;
        end else begin
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + 5'd1;
        if (cnt_r == DIV_LAST) state_nxt = S_MEAN;
      end
      S_MEAN: begin
        cmd.set_mean = 1'b1;
        cnt_nxt      = '0;
        state_nxt    = S_SQ;
      end
      S_SQ: begin
        cmd.sq_en = 1'b1;
        cnt_nxt   = cnt_r + 5'd1;
        if (cnt_r[1:0] == gwh_pkg::SQ_RAD) state_nxt = S_CMP;
      end
      S_CMP: begin
        cnt_nxt = '0;
        if (sts.reached) begin
          cmd.set_reached = 1'b1;
          state_nxt       = S_DONE;
        end else begin
          cmd.cor_init = 1'b1;
          state_nxt    = S_COR;
        end
      end
      S_COR: begin
        cmd.cor_step = 1'b1;
        cnt_nxt      = cnt_r + 5'd1;
        if (cnt_r == COR_LAST) state_nxt = S_FIN;
      end
      S_FIN: begin
        cmd.cor_fin = 1'b1;
        state_nxt   = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

`include "gps_waypoint_heading_top_assert.svh"
  `GWH_ASSERT_NXT(a_accept_conv, in_valid && !in_stall, state_r == S_CONV, "item not converted")
  `GWH_ASSERT_NXT(a_div_len, state_r == S_DIV && cnt_r == DIV_LAST, state_r == S_MEAN, "divider overrun")
  `GWH_ASSERT_NXT(a_done_hold, state_r == S_DONE && out_valid_r && out_stall, state_r == S_DONE && out_valid_r, "result overwritten")
  `GWH_ASSERT_IMP(a_out_drop, $fell(out_valid_r), $past(!out_stall), "result dropped")

endmodule

/* design/gps_waypoint_heading_top.sv */
// Waypoint heading top level: averages fixes per window and reports bearing or arrival.
// An item that does not close a window passes through capture, BCD conversion and
// accumulate. An item that closes a window with no fix is marked lost in the result register
// at accumulate; otherwise the shared one-bit-per-cycle divider, the squaring sequence
// through one multiplier and, unless the destination is reached, the CORDIC unit follow.
// A finished result waits in the output register while the next item is taken.
module gps_waypoint_heading_top #(
  parameter int CORDIC_STEPS = gwh_pkg::CORDIC_STEPS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_fix_valid,
  input  logic [31:0] in_latitude_bcd,
  input  logic [35:0] in_longitude_bcd,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_nav_status,
  output logic [15:0] out_heading,
  output logic [25:0] out_mean_latitude,
  output logic [26:0] out_mean_longitude,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  gwh_pkg::cfg_t cfg;
  gwh_pkg::cmd_t cmd;
  gwh_pkg::sts_t sts;

  gwh_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  gwh_ctrl #(.CORDIC_STEPS(CORDIC_STEPS)) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  gwh_dp u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .cfg                (cfg),
    .in_fix_valid       (in_fix_valid),
    .in_latitude_bcd    (in_latitude_bcd),
    .in_longitude_bcd   (in_longitude_bcd),
    .sts                (sts),
    .out_nav_status     (out_nav_status),
    .out_heading        (out_heading),
    .out_mean_latitude  (out_mean_latitude),
    .out_mean_longitude (out_mean_longitude)
  );

endmodule

/* sim/gps_waypoint_heading_checker.sv */
// Checker for the waypoint heading block: watches input, output and APB writes, predicts results and compares
module gps_waypoint_heading_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic        in_fix_valid,
  input  logic [31:0] in_latitude_bcd,
  input  logic [35:0] in_longitude_bcd,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [1:0]  out_nav_status,
  input  logic [15:0] out_heading,
  input  logic [25:0] out_mean_latitude,
  input  logic [26:0] out_mean_longitude,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic        pready,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output int          fail_count,
  output int          pending_count
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] heading;
    logic [25:0] mlat;
    logic [26:0] mlon;
  } nav_t;

  localparam longint ANG_HALF = 64'sd1179648000;
  localparam longint ANG_FULL = 64'sd2359296000;
  localparam int     STEPS    = gwh_pkg::CORDIC_STEPS_DEF;

  logic [25:0] dest_lat;
  logic [26:0] dest_lon;
  logic [15:0] radius;
  logic [3:0]  window;
  logic [3:0]  ticks, fixes;
  logic [29:0] lat_sum;
  logic [30:0] lon_sum;
  nav_t        expected_navs[$];

  assign pending_count = expected_navs.size();

  function automatic longint bcd_to_int(input logic [35:0] v, input int digits);
    longint acc;
    acc = 0;
    for (int k = digits; k > 0; k--) acc = acc * 10 + v[(k-1)*4 +: 4];
    return acc;
  endfunction

  function automatic longint sra(input longint v, input int s);
    return v >>> s;
  endfunction

  function automatic logic [15:0] bearing_of(input longint dlat, input longint dlon);
    longint x, y, z, nx, h;
    x = dlat * 65536;
    y = dlon * 65536;
    z = 0;
    if (x < 0) begin
      z = (y >= 0) ? ANG_HALF : -ANG_HALF;
      x = -x;
      y = -y;
    end
    for (int i = 0; i < STEPS; i++) begin
      if (y >= 0) begin
        nx = x + sra(y, i);
        y = y - sra(x, i);
        z += longint'(gwh_pkg::atan_ent(i[4:0]));
      end else begin
        nx = x - sra(y, i);
        y = y + sra(x, i);
        z -= longint'(gwh_pkg::atan_ent(i[4:0]));
      end
      x = nx;
    end
    if (z < 0) z += ANG_FULL;
    if (z < 0) z = 0;
    h = (z + 32768) >>> 16;
    if (h >= 36000) h -= 36000;
    return h[15:0];
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
    fail_count++;
  endtask

  task automatic advance_window(input logic fix, input logic [31:0] lat_bcd,
                                input logic [35:0] lon_bcd);
    longint lat, lon, mlat, mlon, dlat, dlon;
    logic [3:0] nxt, win;
    nav_t r;
    nxt = ticks + 4'd1;
    win = (window == 0) ? 4'd1 : window;
    if (fix) begin
      lat = bcd_to_int(lat_bcd >> 24, 2) * 600000 + bcd_to_int(lat_bcd, 6);
      lon = bcd_to_int(lon_bcd >> 24, 3) * 600000 + bcd_to_int(lon_bcd, 6);
      if (lat > 54000000) lat = 54000000;
      if (lon > 108000000) lon = 108000000;
      lat_sum = lat_sum + lat[29:0];
      lon_sum = lon_sum + lon[30:0];
      fixes = fixes + 4'd1;
    end
    if (ticks != 4'hf && nxt < win) begin
      ticks = nxt;
      return;
    end
    r = '0;
    if (fixes != 0) begin
      mlat = lat_sum / fixes;
      mlon = lon_sum / fixes;
      r.mlat = mlat[25:0];
      r.mlon = mlon[26:0];
      dlat = longint'(dest_lat) - mlat;
      dlon = longint'(dest_lon) - mlon;
      if (dlat * dlat + dlon * dlon <= longint'(radius) * longint'(radius))
        r.status = gwh_pkg::NAV_REACHED;
      else begin
        r.status = gwh_pkg::NAV_HEADING;
        r.heading = bearing_of(dlat, dlon);
      end
    end else r.status = gwh_pkg::NAV_LOST;
    expected_navs.push_back(r);
    ticks = 0;
    fixes = 0;
    lat_sum = 0;
    lon_sum = 0;
  endtask

  always @(posedge clk) begin
    nav_t w;
    if (!rst_n) begin
      dest_lat = 0;
      dest_lon = 0;
      radius = 16'd30;
      window = 4'd10;
      ticks = 0;
      fixes = 0;
      lat_sum = 0;
      lon_sum = 0;
      fail_count = 0;
      expected_navs.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          gwh_pkg::REG_DEST_LAT: dest_lat = pwdata[25:0];
          gwh_pkg::REG_DEST_LON: dest_lon = pwdata[26:0];
          gwh_pkg::REG_RADIUS:   radius = pwdata[15:0];
          gwh_pkg::REG_WINDOW:   window = pwdata[3:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall)
        advance_window(in_fix_valid, in_latitude_bcd, in_longitude_bcd);
      if (out_valid && !out_stall) begin
        if (expected_navs.size() == 0) begin
          report_mismatch("unexpected item status", out_nav_status, -1);
        end else begin
          w = expected_navs.pop_front();
          if (out_nav_status !== w.status)
            report_mismatch("nav_status", out_nav_status, w.status);
          if (out_heading !== w.heading) report_mismatch("heading", out_heading, w.heading);
          if (out_mean_latitude !== w.mlat)
            report_mismatch("mean_latitude", out_mean_latitude, w.mlat);
          if (out_mean_longitude !== w.mlon)
            report_mismatch("mean_longitude", out_mean_longitude, w.mlon);
        end
      end
    end
  end
endmodule

/* sim/gps_waypoint_heading_top_test.sv */
// Testbench top for the waypoint heading block: stimulus, register writes and verdict
module gps_waypoint_heading_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        in_fix_valid = 1'b0;
  logic [31:0] in_latitude_bcd = '0;
  logic [35:0] in_longitude_bcd = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  out_nav_status;
  logic [15:0] out_heading;
  logic [25:0] out_mean_latitude;
  logic [26:0] out_mean_longitude;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  int          fail_count;
  int          pending_count;
  bit          long_hold = 1'b0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  gps_waypoint_heading_top u_top (.*);

  gps_waypoint_heading_checker u_checker (.*);

  function automatic int gap_len();
    if ($urandom_range(0, 19) == 0) return $urandom_range(10, 80);
    if ($urandom_range(0, 2) == 0) return 0;
    return $urandom_range(0, 3);
  endfunction

  always @(posedge clk) begin
    if (long_hold) out_stall <= 1'b1;
    else if ($urandom_range(0, 3) == 0) out_stall <= 1'b1;
    else out_stall <= 1'b0;
  end

  function automatic logic [3:0] digit();
    return ($urandom_range(0, 15) == 0) ? 4'($urandom_range(10, 15)) : 4'($urandom_range(0, 9));
  endfunction

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    in_valid <= 1'b0;
    @(posedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic send_fix(input logic fix, input logic [31:0] lat, input logic [35:0] lon,
                          input bit gaps);
    int g;
    g = gaps ? gap_len() : 0;
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_fix_valid <= fix;
    in_latitude_bcd <= lat;
    in_longitude_bcd <= lon;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic send_random(input int kind);
    logic [31:0] lat;
    logic [35:0] lon;
    for (int k = 0; k < 8; k++) lat[k*4 +: 4] = digit();
    for (int k = 0; k < 9; k++) lon[k*4 +: 4] = digit();
    if (kind == 0) begin
      lat = $urandom();
      lon = {4'($urandom()), 32'($urandom())};
    end else if (kind == 1) begin
      lat[31:24] = 8'h45;
      lon[35:24] = 12'h122;
      lat[23:16] = 8'h30;
    end
    send_fix($urandom_range(0, 9) != 0, lat, lon, 1'b1);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_count != 0) @(posedge clk);
    repeat (120) @(posedge clk);
  endtask

  task automatic run_phase(input logic [25:0] dlat, input logic [26:0] dlon,
                           input logic [15:0] rad, input logic [3:0] win, input int n);
    drain();
    write_reg(gwh_pkg::REG_DEST_LAT, 32'(dlat));
    write_reg(gwh_pkg::REG_DEST_LON, 32'(dlon));
    write_reg(gwh_pkg::REG_RADIUS, 32'(rad));
    write_reg(gwh_pkg::REG_WINDOW, 32'(win));
    for (int i = 0; i < n; i++)
      send_random($urandom_range(0, 9) == 0 ? 0 : 1 + $urandom_range(0, 1));
  endtask

  initial begin
    #10_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    send_fix(1'b0, '0, '0, 1'b0);
    send_fix(1'b1, 32'h0000_0000, 36'h0_0000_0000, 1'b0);
    send_fix(1'b1, 32'hFFFF_FFFF, 36'hF_FFFF_FFFF, 1'b0);
    send_fix(1'b1, 32'h9000_0000, 36'h1_8000_0000, 1'b0);
    send_fix(1'b1, 32'h8959_9999, 36'h1_7959_9999, 1'b0);
    send_fix(1'b1, 32'h4530_1234, 36'h1_2245_6789, 1'b0);
    for (int i = 0; i < 4; i++) send_fix(1'b0, '0, '0, 1'b0);
    for (int i = 0; i < 10; i++) send_fix(1'b0, 32'hFFFF_FFFF, 36'hF_FFFF_FFFF, 1'b0);
    drain();
    write_reg(gwh_pkg::REG_DEST_LAT, 32'd27000000);
    write_reg(gwh_pkg::REG_DEST_LON, 32'd54000000);
    write_reg(gwh_pkg::REG_RADIUS, 32'd65535);
    write_reg(gwh_pkg::REG_WINDOW, 32'd0);
    send_fix(1'b1, 32'h4500_0000, 36'h0_9000_0000, 1'b0);
    send_fix(1'b1, 32'h4400_0000, 36'h0_9000_0000, 1'b0);
    send_fix(1'b1, 32'h4600_0000, 36'h0_8900_0000, 1'b0);
    drain();
    write_reg(gwh_pkg::REG_WINDOW, 32'd15);
    for (int i = 0; i < 5; i++) send_fix(1'b1, 32'h2000_0000, 36'h0_4000_0000, 1'b0);
    write_reg(gwh_pkg::REG_WINDOW, 32'd3);
    send_fix(1'b1, 32'h2000_0000, 36'h0_4000_0000, 1'b0);
    run_phase(26'd0, 27'd0, 16'd0, 4'd1, 250);
    run_phase(26'd27180000, 27'd73350000, 16'd30, 4'd4, 300);
    fork
      begin
        long_hold = 1'b1;
        repeat (400) @(posedge clk);
        long_hold = 1'b0;
      end
      for (int i = 0; i < 40; i++) send_fix(1'b1, 32'h4530_0000, 36'h1_2230_0000, 1'b0);
    join
    run_phase(26'd54000000, 27'd108000000, 16'd65535, 4'd15, 300);
    run_phase(26'($urandom_range(0, 54000000)), 27'($urandom_range(0, 108000000)),
              16'd0, 4'd2, 300);
    run_phase(26'd27300000, 27'd73500000, 16'd200, 4'd10, 300);
    run_phase(26'd0, 27'd0, 16'd1000, 4'd0, 200);
    drain();
    if (fail_count == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end
endmodule

/* files.f */
+incdir+design
design/gwh_pkg.sv
design/gwh_regs.sv
design/gwh_dp.sv
design/gwh_ctrl.sv
design/gps_waypoint_heading_top.sv
sim/gps_waypoint_heading_checker.sv
sim/gps_waypoint_heading_top_test.sv
